[sv/tsbo_pkg.sv]
// Shared types and constants of the thick segment versus box overlap block.
package tsbo_pkg;

  // Default coordinate format: signed Q16.16.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Configuration register index width.
  localparam int CFG_ADDR_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_END_X     = 3'd2,
    REG_END_Y     = 3'd3,
    REG_THICKNESS = 3'd4
  } cfg_reg_e;

  // Stage enables handed to each side-crossing lane.
  typedef struct packed {
    logic en2;
    logic en3;
  } lane_ctl_t;

endpackage

[sv/tsbo_cfg.sv]
// Configuration registers and the bit-serial unit that derives length, offset and corners.
module tsbo_cfg import tsbo_pkg::*; #(
  parameter int W    = COORD_WIDTH_DEF,
  parameter int FRAC = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [W-1:0]          cfg_wdata_i,
  output logic                  busy_o,
  output logic signed [W-1:0]   sx_o,
  output logic signed [W-1:0]   sy_o,
  output logic signed [W:0]     dx_o,
  output logic signed [W:0]     dy_o,
  output logic [W:0]            mdx_o,
  output logic [W:0]            mdy_o,
  output logic [3:0][W:0]       cx_o,
  output logic [3:0][W:0]       cy_o
);

  localparam int LW   = W + 1;
  localparam int SW   = 2 * LW;
  localparam int RW   = LW + 3;
  localparam int NW   = 2 * W;
  localparam int RDW  = W + 3;
  localparam int CNTW = $clog2(2 * W);
  localparam logic [W-2:0] THICK_RST = (W-1)'(((64'd1 << FRAC) + 64'd5) / 64'd10);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_MUL, ST_SUM, ST_SQRT, ST_DIV, ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;

  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [W-2:0]        th_q;

  logic signed [W:0] dx_q, dy_q, dx_d, dy_d;
  logic [W:0]        mdx_q, mdy_q, mdx_d, mdy_d;
  logic [SW-1:0]     sqx_q, sqy_q, s_q;
  logic [NW-1:0]     numx_q, numy_q;
  logic [RW-1:0]     rem_q, rem_sh, trial;
  logic [LW-1:0]     root_q;
  logic [RDW-1:0]    drx_q, dry_q, dshx, dshy, dvs;
  logic [W-2:0]      qx_q, qy_q;
  logic [3:0][W:0]   cx_q, cy_q;
  logic signed [W-1:0] mxs, mys, ox, oy;
  logic signed [W:0]   oxe, oye, sxe, sye, exe, eye;

  // Register file; every write restarts the derivation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      ex_q <= '0;
      ey_q <= '0;
      th_q <= THICK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_START_X:   sx_q <= cfg_wdata_i;
        REG_START_Y:   sy_q <= cfg_wdata_i;
        REG_END_X:     ex_q <= cfg_wdata_i;
        REG_END_Y:     ey_q <= cfg_wdata_i;
        REG_THICKNESS: th_q <= cfg_wdata_i[W-2:0];
        default:       ;
      endcase
    end
  end

  // Sequencer: difference, squares, sum, root, divide, corners.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (cfg_we_i) begin
      state_d = ST_DIFF;
    end else begin
      unique case (state_q)
        ST_IDLE: state_d = ST_IDLE;
        ST_DIFF: state_d = ST_MUL;
        ST_MUL:  state_d = ST_SUM;
        ST_SUM: begin
          state_d = ST_SQRT;
          cnt_d   = CNTW'(LW - 1);
        end
        ST_SQRT: begin
          if (cnt_q == '0) begin
            state_d = ST_DIV;
            cnt_d   = CNTW'(NW - 1);
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_d = ST_FIN;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        ST_FIN:  state_d = ST_IDLE;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DIFF;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Step logic of the differences, the root, the two dividers and the corner offsets.
  always_comb begin
    dx_d   = $signed({ex_q[W-1], ex_q}) - $signed({sx_q[W-1], sx_q});
    dy_d   = $signed({ey_q[W-1], ey_q}) - $signed({sy_q[W-1], sy_q});
    mdx_d  = dx_d[W] ? $unsigned(-dx_d) : $unsigned(dx_d);
    mdy_d  = dy_d[W] ? $unsigned(-dy_d) : $unsigned(dy_d);
    rem_sh = {rem_q[RW-3:0], s_q[SW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    dvs    = {1'b0, root_q, 1'b0};
    dshx   = {drx_q[RDW-2:0], numx_q[NW-1]};
    dshy   = {dry_q[RDW-2:0], numy_q[NW-1]};
    mxs    = $signed({1'b0, qx_q});
    mys    = $signed({1'b0, qy_q});
    if (root_q == '0) begin
      ox = '0;
      oy = '0;
    end else begin
      ox = (!dy_q[W] && dy_q != '0) ? -mxs : mxs;
      oy = dx_q[W] ? -mys : mys;
    end
    oxe = {ox[W-1], ox};
    oye = {oy[W-1], oy};
    sxe = {sx_q[W-1], sx_q};
    sye = {sy_q[W-1], sy_q};
    exe = {ex_q[W-1], ex_q};
    eye = {ey_q[W-1], ey_q};
  end

  // Datapath registers, advanced by the sequencer state.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_DIFF: begin
        dx_q  <= dx_d;
        dy_q  <= dy_d;
        mdx_q <= mdx_d;
        mdy_q <= mdy_d;
      end
      ST_MUL: begin
        sqx_q  <= SW'(mdx_q) * SW'(mdx_q);
        sqy_q  <= SW'(mdy_q) * SW'(mdy_q);
        numx_q <= NW'(mdy_q) * NW'(th_q);
        numy_q <= NW'(mdx_q) * NW'(th_q);
      end
      ST_SUM: begin
        s_q    <= sqx_q + sqy_q;
        rem_q  <= '0;
        root_q <= '0;
        drx_q  <= '0;
        dry_q  <= '0;
        qx_q   <= '0;
        qy_q   <= '0;
      end
      ST_SQRT: begin
        s_q <= {s_q[SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[LW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[LW-2:0], 1'b0};
        end
      end
      ST_DIV: begin
        numx_q <= {numx_q[NW-2:0], 1'b0};
        numy_q <= {numy_q[NW-2:0], 1'b0};
        if (dshx >= dvs) begin
          drx_q <= dshx - dvs;
          qx_q  <= {qx_q[W-3:0], 1'b1};
        end else begin
          drx_q <= dshx;
          qx_q  <= {qx_q[W-3:0], 1'b0};
        end
        if (dshy >= dvs) begin
          dry_q <= dshy - dvs;
          qy_q  <= {qy_q[W-3:0], 1'b1};
        end else begin
          dry_q <= dshy;
          qy_q  <= {qy_q[W-3:0], 1'b0};
        end
      end
      ST_FIN: begin
        cx_q[0] <= sxe + oxe;
        cy_q[0] <= sye + oye;
        cx_q[1] <= sxe - oxe;
        cy_q[1] <= sye - oye;
        cx_q[2] <= exe + oxe;
        cy_q[2] <= eye + oye;
        cx_q[3] <= exe - oxe;
        cy_q[3] <= eye - oye;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign sx_o   = sx_q;
  assign sy_o   = sy_q;
  assign dx_o   = dx_q;
  assign dy_o   = dy_q;
  assign mdx_o  = mdx_q;
  assign mdy_o  = mdy_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;

endmodule

[sv/tsbo_xlane.sv]
// One side-crossing lane: range check of the crossing point without a divider.
module tsbo_xlane import tsbo_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  lane_ctl_t           ctl_i,
  input  logic signed [W-1:0] su_i,
  input  logic signed [W-1:0] sv_i,
  input  logic signed [W:0]   du_i,
  input  logic signed [W:0]   dv_i,
  input  logic [W:0]          mdu_i,
  input  logic [W:0]          mdv_i,
  input  logic signed [W-1:0] b_i,
  input  logic signed [W-1:0] vlo_i,
  input  logic signed [W-1:0] vhi_i,
  output logic                hit_o
);

  localparam int PW = 2 * W + 2;

  logic signed [W:0]   n, lo, hi;
  logic [W:0]          mn;
  logic                ok, neg;
  logic signed [W+1:0] a_v, b_v;

  logic [W:0]          mn_q;
  logic signed [W+1:0] a_q, b_q;
  logic                ok_q;

  logic [W:0]          ap, bp1;
  logic                ale;
  logic [PW-1:0]       p_q, ad_q, bd_q;
  logic                ok3_q, ale_q;

  // Side offset, parameter range and the bounds on the scaled crossing.
  // The crossing q = s*floor(P/D) must meet lo <= q <= hi; with the sign
  // folded in this is A <= floor(P/D) <= B.
  always_comb begin
    n   = $signed({b_i[W-1], b_i}) - $signed({su_i[W-1], su_i});
    mn  = n[W] ? $unsigned(-n) : $unsigned(n);
    ok  = (du_i != '0) && ((n == '0) || ((n[W] == du_i[W]) && (mn <= mdu_i)));
    neg = n[W] ^ du_i[W] ^ dv_i[W];
    lo  = $signed({vlo_i[W-1], vlo_i}) - $signed({sv_i[W-1], sv_i});
    hi  = $signed({vhi_i[W-1], vhi_i}) - $signed({sv_i[W-1], sv_i});
    a_v = neg ? -$signed({hi[W], hi}) : $signed({lo[W], lo});
    b_v = neg ? -$signed({lo[W], lo}) : $signed({hi[W], hi});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      mn_q <= mn;
      a_q  <= a_v;
      b_q  <= b_v;
      ok_q <= ok;
    end
  end

  // Cross products: floor(P/D) >= A is P >= A*D, floor(P/D) <= B is P < (B+1)*D.
  always_comb begin
    ale = (a_q <= 0);
    ap  = ale ? '0 : a_q[W:0];
    bp1 = b_q[W:0] + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      p_q   <= PW'(mdv_i) * PW'(mn_q);
      ad_q  <= PW'(ap) * PW'(mdu_i);
      bd_q  <= PW'(bp1) * PW'(mdu_i);
      ok3_q <= ok_q && !b_q[W+1];
      ale_q <= ale;
    end
  end

  assign hit_o = ok3_q && (ale_q || (p_q >= ad_q)) && (p_q < bd_q);

endmodule

[sv/thick_segment_box_overlap_top.sv]
// Throughput one box per cycle while the output is taken and the configuration unit is idle.
// The four-stage pipeline stalls as a whole only where a stage holds a beat not yet taken.
// After reset and after every configuration write the input is not ready while the
// geometry is derived by the bit-serial root and the two bit-serial dividers.
// Reset is asynchronous and active low; registers reset to their listed values.
module thick_segment_box_overlap_top import tsbo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COORD_WIDTH-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  is_box_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o
);

  localparam int W = COORD_WIDTH;

  logic                busy;
  logic signed [W-1:0] sx, sy;
  logic signed [W:0]   dx, dy;
  logic [W:0]          mdx, mdy;
  logic [3:0][W:0]     cx, cy;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic box1_q, box2_q, box3_q;
  logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic corner2_q, corner3_q, hit_q;
  logic [3:0] in_k, lane_hit;
  logic signed [W:0] x0e, y0e, x1e, y1e;
  lane_ctl_t ctl;

  tsbo_cfg #(.W(W), .FRAC(FRAC_BITS)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .busy_o(busy), .sx_o(sx), .sy_o(sy), .dx_o(dx), .dy_o(dy),
    .mdx_o(mdx), .mdy_o(mdy), .cx_o(cx), .cy_o(cy)
  );

  // Backpressure: a stage moves when it is empty or its successor moves.
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1 && !busy;
  assign ctl.en2    = rdy2;
  assign ctl.en3    = rdy3;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i && !busy;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Input stage.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      box1_q <= is_box_i;
      x0_q   <= box_min_x_i;
      y0_q   <= box_min_y_i;
      x1_q   <= box_max_x_i;
      y1_q   <= box_max_y_i;
    end
  end

  // Corner containment against the box, borders included.
  always_comb begin
    x0e = {x0_q[W-1], x0_q};
    y0e = {y0_q[W-1], y0_q};
    x1e = {x1_q[W-1], x1_q};
    y1e = {y1_q[W-1], y1_q};
    for (int k = 0; k < 4; k++) begin
      in_k[k] = ($signed(cx[k]) >= x0e) && ($signed(cx[k]) <= x1e) &&
                ($signed(cy[k]) >= y0e) && ($signed(cy[k]) <= y1e);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      box2_q    <= box1_q;
      corner2_q <= |in_k;
    end
    if (rdy3) begin
      box3_q    <= box2_q;
      corner3_q <= corner2_q;
    end
    if (rdy4) begin
      hit_q <= box3_q && (corner3_q || (|lane_hit));
    end
  end

  // Crossings of the vertical sides.
  tsbo_xlane #(.W(W)) u_lane_xmin (
    .clk_i, .ctl_i(ctl), .su_i(sx), .sv_i(sy), .du_i(dx), .dv_i(dy),
    .mdu_i(mdx), .mdv_i(mdy), .b_i(x0_q), .vlo_i(y0_q), .vhi_i(y1_q),
    .hit_o(lane_hit[0])
  );
  tsbo_xlane #(.W(W)) u_lane_xmax (
    .clk_i, .ctl_i(ctl), .su_i(sx), .sv_i(sy), .du_i(dx), .dv_i(dy),
    .mdu_i(mdx), .mdv_i(mdy), .b_i(x1_q), .vlo_i(y0_q), .vhi_i(y1_q),
    .hit_o(lane_hit[1])
  );

  // Crossings of the horizontal sides.
  tsbo_xlane #(.W(W)) u_lane_ymin (
    .clk_i, .ctl_i(ctl), .su_i(sy), .sv_i(sx), .du_i(dy), .dv_i(dx),
    .mdu_i(mdy), .mdv_i(mdx), .b_i(y0_q), .vlo_i(x0_q), .vhi_i(x1_q),
    .hit_o(lane_hit[2])
  );
  tsbo_xlane #(.W(W)) u_lane_ymax (
    .clk_i, .ctl_i(ctl), .su_i(sy), .sv_i(sx), .du_i(dy), .dv_i(dx),
    .mdu_i(mdy), .mdv_i(mdx), .b_i(y1_q), .vlo_i(x0_q), .vhi_i(x1_q),
    .hit_o(lane_hit[3])
  );

  assign out_valid_o = v4_q;
  assign hit_o       = hit_q;

  // A beat leaving the third stage always lands in the output register.
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> v4_q)
    else $error("beat lost at output stage");

  // A non-rectangle never reports a hit.
  a_not_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !box3_q && rdy4) |=> (v4_q && !hit_q))
    else $error("hit reported for a non-box collider");

  // A configuration write holds off input while the geometry is rederived.
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input accepted during geometry update");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the thick segment versus box overlap block.
`timescale 1ns / 1ps

module testbench;
  import tsbo_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int LAT = 4;

  typedef struct packed {
    logic is_box;
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = REG_START_X;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic is_box_i = 1'b0;
  logic signed [CW-1:0] box_min_x_i = '0, box_min_y_i = '0;
  logic signed [CW-1:0] box_max_x_i = '0, box_max_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;

  thick_segment_box_overlap_top uut (.*);

  always #10 clk_i = ~clk_i;

  // Segment and band width as the predictor sees them.
  logic signed [CW-1:0] seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
  logic [CW-2:0] band_w = 31'd6554;

  box_t box_queue[$];
  logic hit_queue[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int n_errors = 0, n_hits = 0, n_checked = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Integer square root of a 128-bit value.
  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  // Centre line crossing the side u = b, checked against [vlo, vhi].
  function automatic logic side_cross(input longint su, sv, du, dv, b, vlo, vhi);
    longint n, q, w;
    logic [127:0] m;
    n = b - su;
    if (du == 0) return 1'b0;
    if (n != 0 && (((n < 0) != (du < 0)) || mag64(n) > mag64(du))) return 1'b0;
    m = (128'(mag64(dv)) * 128'(mag64(n))) / 128'(mag64(du));
    q = longint'(m[63:0]);
    if ((((dv < 0) != (n < 0)) != (du < 0)) && dv != 0 && n != 0) q = -q;
    w = sv + q;
    return w >= vlo && w <= vhi;
  endfunction

  function automatic logic corner_in(input longint x, y, x0, y0, x1, y1);
    return x >= x0 && x <= x1 && y >= y0 && y <= y1;
  endfunction

  function automatic logic predict_hit(input box_t bx);
    longint sx, sy, ex, ey, x0, y0, x1, y1, dx, dy, ox, oy;
    logic [63:0] len, mx, my;
    sx = seg_sx; sy = seg_sy; ex = seg_ex; ey = seg_ey;
    x0 = bx.min_x; y0 = bx.min_y; x1 = bx.max_x; y1 = bx.max_y;
    dx = ex - sx; dy = ey - sy;
    ox = 0; oy = 0;
    if (!bx.is_box) return 1'b0;
    len = isqrt128(128'(mag64(dx)) * 128'(mag64(dx)) + 128'(mag64(dy)) * 128'(mag64(dy)));
    if (len != 0) begin
      mx = 64'((128'(mag64(dy)) * 128'(band_w)) / (128'(len) * 2));
      my = 64'((128'(mag64(dx)) * 128'(band_w)) / (128'(len) * 2));
      ox = dy > 0 ? -longint'(mx) : longint'(mx);
      oy = dx < 0 ? -longint'(my) : longint'(my);
    end
    if (corner_in(sx + ox, sy + oy, x0, y0, x1, y1) ||
        corner_in(sx - ox, sy - oy, x0, y0, x1, y1) ||
        corner_in(ex + ox, ey + oy, x0, y0, x1, y1) ||
        corner_in(ex - ox, ey - oy, x0, y0, x1, y1))
      return 1'b1;
    return side_cross(sx, sy, dx, dy, x0, y0, y1) || side_cross(sx, sy, dx, dy, x1, y0, y1) ||
           side_cross(sy, sx, dy, dx, y0, x0, x1) || side_cross(sy, sx, dy, dx, y1, x0, x1);
  endfunction

  // Driver: presents queued boxes, holding each beat until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (box_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          box_t bx;
          bx = box_queue.pop_front();
          hit_queue.push_back(predict_hit(bx));
          in_valid_i <= 1'b1;
          is_box_i <= bx.is_box;
          box_min_x_i <= bx.min_x;
          box_min_y_i <= bx.min_y;
          box_max_x_i <= bx.max_x;
          box_max_y_i <= bx.max_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each hit beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hit_queue.size() == 0) begin
        report_mismatch("hit beat with no box pending");
      end else begin
        logic want;
        want = hit_queue.pop_front();
        n_checked++;
        if (want) n_hits++;
        if (hit_o !== want)
          report_mismatch($sformatf("hit %b, expected %b", hit_o, want));
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_START_X: seg_sx = val;
      REG_START_Y: seg_sy = val;
      REG_END_X: seg_ex = val;
      REG_END_Y: seg_ey = val;
      default: band_w = val[CW-2:0];
    endcase
  endtask

  task automatic set_segment(input logic [CW-1:0] sx, sy, ex, ey, th);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_THICKNESS, th);
  endtask

  // Waits until every beat is sent and every hit has come back.
  task automatic drain();
    while (box_queue.size() > 0 || in_valid_i || hit_queue.size() > 0) @(posedge clk_i);
    repeat (LAT + 2) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rnd_coord(input int span);
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 1'b1 : 1'b0, {(CW-1){1'b0}}} |
                ($urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : '0);
      default: return CW'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // Random box, most often placed near the segment so that both outcomes are frequent.
  task automatic push_random(input int span);
    box_t bx;
    longint cx, cy, hw, hh;
    bx.is_box = ($urandom_range(15) != 0);
    if ($urandom_range(9) < 2) begin
      bx.min_x = $urandom(); bx.min_y = $urandom();
      bx.max_x = $urandom(); bx.max_y = $urandom();
    end else begin
      cx = longint'(seg_sx)
           + (longint'(seg_ex) - longint'(seg_sx)) * longint'($urandom_range(140)) / 100
           - (longint'(seg_ex) - longint'(seg_sx)) / 5
           + longint'($urandom_range(2 * span)) - span;
      cy = longint'(seg_sy) + longint'($urandom_range(2 * span)) - span;
      hw = $urandom_range(span);
      hh = $urandom_range(span);
      bx.min_x = CW'(cx - hw); bx.max_x = CW'(cx + hw);
      bx.min_y = CW'(cy - hh); bx.max_y = CW'(cy + hh);
      if ($urandom_range(19) == 0) begin
        bx.min_y = CW'(cy + hh + 1); bx.max_y = CW'(cy - hh);
      end
    end
    box_queue.push_back(bx);
  endtask

  task automatic push_box(input logic b, input logic [CW-1:0] x0, y0, x1, y1);
    box_queue.push_back('{b, x0, y0, x1, y1});
  endtask

  localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default zero-length segment at the origin.
    push_box(1'b1, -100, -100, 100, 100);
    push_box(1'b0, MINN, MINN, MAXP, MAXP);
    push_box(1'b1, 1, 1, 100, 100);
    push_box(1'b1, MINN, MINN, MAXP, MAXP);
    push_box(1'b1, 100, -100, -100, 100);
    drain();

    // Directed: horizontal segment, crossings and band edges.
    set_segment(-32'sd655360, 0, 32'sd655360, 0, 32'sd65536);
    push_box(1'b1, -65536, -65536, 65536, 65536);
    push_box(1'b1, -65536, 32768, 65536, 65536);
    push_box(1'b1, -65536, 32769, 65536, 65536);
    push_box(1'b1, 655360, -1, 700000, 1);
    push_box(1'b1, 800000, -10, 900000, 10);
    push_box(1'b1, 0, 40000, 10, 50000);
    push_box(1'b1, MINN, MINN, MAXP, MAXP);
    push_box(1'b1, MAXP, MAXP, MINN, MINN);
    drain();

    // Directed: extreme diagonal with the widest band.
    set_segment(MINN, MINN, MAXP, MAXP, MAXP);
    push_box(1'b1, -10, -10, 10, 10);
    push_box(1'b1, MAXP, MAXP, MAXP, MAXP);
    push_box(1'b1, MINN, MAXP, MINN, MAXP);
    push_box(1'b1, 0, 1000, 10, 2000);
    push_box(1'b1, -5, 5, 5, 5);
    push_box(1'b0, -5, -5, 5, 5);
    drain();

    // Random phases, each with its own segment and one of three idle patterns.
    for (int ph = 0; ph < 9; ph++) begin
      int span;
      span = (ph % 3 == 0) ? 2000000 : 300000;
      case (ph % 3)
        0: begin send_idle_pct = 32; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 8) set_segment(0, 0, 0, 0, 0);
      else if (ph == 7) set_segment(rnd_coord(span), rnd_coord(span), rnd_coord(span),
                                    rnd_coord(span), MAXP);
      else set_segment(CW'(int'($urandom_range(2 * span)) - span),
                       CW'(int'($urandom_range(2 * span)) - span),
                       CW'(int'($urandom_range(2 * span)) - span),
                       CW'(int'($urandom_range(2 * span)) - span),
                       $urandom_range(200000));
      for (int k = 0; k < 78; k++) push_random(span);
      // Hold the sender back once mid-phase until every hit is in.
      if (ph == 4) begin
        drain();
        for (int k = 0; k < 10; k++) push_random(span);
      end
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;

    $display("Checked %0d boxes over 12 segment settings, %0d of them hits.",
             n_checked, n_hits);
    if (n_errors == 0) begin
      $display("[thick_segment_box_overlap_top] OK");
    end else begin
      $display("[thick_segment_box_overlap_top] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("Timeout with %0d hits pending.", hit_queue.size());
    $display("[thick_segment_box_overlap_top] ERROR");
    $finish;
  end

endmodule
